### sv/mecd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multi-encoding character decoder.
// No dependencies; imported by every module of the block.
package mecd_pkg;

    localparam int DEPTH   = 5;     // pending byte buffer entries
    localparam int MAX_RES = 5;     // results allowed per input item
    localparam int CFG_AW  = 2;     // one 32-bit register at byte address 0
    localparam int CFG_DW  = 32;

    typedef logic [1:0] t_enc;
    localparam t_enc ENC_UTF8    = 2'd0;
    localparam t_enc ENC_UTF16LE = 2'd1;
    localparam t_enc ENC_UTF16BE = 2'd2;
    localparam t_enc ENC_GBK     = 2'd3;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_NEWLINE = 3'd0;
    localparam t_kind KIND_TAB     = 3'd1;
    localparam t_kind KIND_SKIP    = 3'd2;
    localparam t_kind KIND_ASCII   = 3'd3;
    localparam t_kind KIND_WIDE    = 3'd4;
    localparam t_kind KIND_TAIL    = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  char_kind;
        logic [7:0]  gbk_high;
        logic [7:0]  gbk_low;
        logic [2:0]  byte_count;
        logic        last_of_run;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic append;     // put the accepted byte into the buffer
        logic load;       // decode head of buffer into stage, consume bytes
        logic move;       // stage -> output register
        logic move_last;  // mark the moved item as last of its run
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic can_emit;   // buffer not empty and the head is decidable
    } t_sts;

endpackage

### sv/multi_encoding_text_char_decoder_core.sv
`timescale 1ns / 1ps
// Top level of the multi-encoding character decoder; holds the APB register.
// Depends on mecd_pkg, mecd_ctrl and mecd_dpath.
//
// Decodes a UTF-8, UTF-16LE, UTF-16BE or GBK byte stream into classified
// characters, one input item per byte and one output item per character;
// CR LF merges into one newline and surrogate pairs are combined. The
// encoding sits in the register at byte address 0 and must be changed only
// while the block is idle; the block itself does not enforce this. One shared
// decoder works on the head of a five-byte pending buffer and yields one
// character per cycle while the output is not stalled; the next byte is taken
// only once every character the last byte completed has left the stage. A
// finished item waits in the output register while the next byte is
// accepted; last_of_run flags the final item caused by a byte.
module multi_encoding_text_char_decoder_core
    import mecd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    t_enc r_text_enc;
    t_cmd cmd;
    t_sts sts;
    logic unused_addr;

    // single register: every address maps onto it
    assign unused_addr = ^paddr;
    assign pready      = 1'b1;
    assign prdata      = {{(CFG_DW-2){unused_addr & 1'b0}}, r_text_enc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_enc <= ENC_UTF8;
        end else if (psel && penable && pwrite && pready) begin
            r_text_enc <= pwdata[1:0];
        end
    end

    mecd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mecd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enc      (r_text_enc),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

endmodule

### sv/mecd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the character decoder: input handshake, result count per
// byte, stage and output register occupancy. Uses mecd_pkg.
module mecd_ctrl
    import mecd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state     r_state, n_state;
    logic       r_stg_vld, n_stg_vld;
    logic       r_out_vld, n_out_vld;
    logic [2:0] r_nres, n_nres;
    logic       out_free;
    logic       more;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign more        = i_sts.can_emit && (r_nres < 3'(MAX_RES));
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state   = r_state;
        n_stg_vld = r_stg_vld;
        n_nres    = r_nres;
        n_out_vld = out_free ? 1'b0 : r_out_vld;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.append = 1'b1;
                    n_nres       = '0;
                    n_state      = S_RUN;
                end
            end
            S_RUN: begin
                if (r_stg_vld) begin
                    // the staged item is last when nothing follows it
                    if (out_free) begin
                        o_cmd.move      = 1'b1;
                        o_cmd.move_last = !more;
                        n_out_vld       = 1'b1;
                        if (more) begin
                            o_cmd.load = 1'b1;
                            n_nres     = r_nres + 3'd1;
                        end else begin
                            n_stg_vld = 1'b0;
                            n_state   = S_IDLE;
                        end
                    end
                end else if (more) begin
                    o_cmd.load = 1'b1;
                    n_stg_vld  = 1'b1;
                    n_nres     = r_nres + 3'd1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stg_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_nres    <= '0;
        end else begin
            r_state   <= n_state;
            r_stg_vld <= n_stg_vld;
            r_out_vld <= n_out_vld;
            r_nres    <= n_nres;
        end
    end

endmodule

### sv/mecd_dpath.sv
`timescale 1ns / 1ps
// Datapath of the character decoder: pending byte buffer, head decoder,
// stage and output registers. Uses mecd_pkg; driven by mecd_ctrl.
module mecd_dpath
    import mecd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_enc      i_enc,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_out_item
);

    typedef struct packed {
        logic        hold;   // more lookahead needed
        logic [2:0]  adv;    // bytes consumed, 0 for the tail mark
        logic [20:0] cp;
        t_kind       kind;
        logic [7:0]  hi;
        logic [7:0]  lo;
    } t_dec;

    logic [7:0]  r_buf [DEPTH];
    logic [7:0]  n_buf [DEPTH];
    logic [7:0]  ext   [2*DEPTH];
    logic [2:0]  r_cnt;
    logic        r_fin;
    t_dec        dec;
    t_dec        r_stg;
    t_out_item   r_out;

    function automatic t_kind f_kind(input logic [20:0] cp, input t_kind dflt);
        t_kind k;
        if (cp == 21'h0A || cp == 21'h0D) k = KIND_NEWLINE;
        else if (cp == 21'h09)            k = KIND_TAB;
        else if (cp < 21'h20)             k = KIND_SKIP;
        else                              k = dflt;
        return k;
    endfunction

    function automatic t_dec f_skip();
        t_dec d;
        d      = '0;
        d.kind = KIND_SKIP;
        d.adv  = 3'd1;
        return d;
    endfunction

    // one-byte character; CR looks ahead for LF
    function automatic t_dec f_single(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [2:0] n, input logic fin);
        t_dec d;
        d      = '0;
        d.cp   = {13'd0, b0};
        d.kind = f_kind(d.cp, KIND_ASCII);
        d.adv  = 3'd1;
        if (b0 == 8'h0D) begin
            if (n >= 3'd2)  d.adv  = (b1 == 8'h0A) ? 3'd2 : 3'd1;
            else if (!fin)  d.hold = 1'b1;
        end
        return d;
    endfunction

    always_comb begin : decide
        logic [15:0] u, u2;
        logic [1:0]  extra;
        logic        lead_ok, bad;
        logic [20:0] cpu;
        dec     = '0;
        u       = (i_enc == ENC_UTF16LE) ? {r_buf[1], r_buf[0]} : {r_buf[0], r_buf[1]};
        u2      = (i_enc == ENC_UTF16LE) ? {r_buf[3], r_buf[2]} : {r_buf[2], r_buf[3]};
        extra   = 2'd0;
        lead_ok = 1'b1;
        bad     = 1'b0;
        cpu     = '0;
        unique case (i_enc) inside
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (r_cnt < 3'd2) begin
                    dec.hold = !r_fin;
                    dec.kind = KIND_TAIL;
                    dec.adv  = 3'd0;
                end else begin
                    dec.cp  = {5'd0, u};
                    dec.adv = 3'd2;
                    if (u[15:10] == 6'b110110) begin
                        if (r_cnt >= 3'd4) begin
                            if (u2[15:10] == 6'b110111) begin
                                dec.cp  = 21'h10000 + {1'b0, u[9:0], u2[9:0]};
                                dec.adv = 3'd4;
                            end
                        end else if (!r_fin) begin
                            dec.hold = 1'b1;
                        end
                    end
                    if (dec.cp == 21'h0D) begin
                        if (r_cnt >= 3'd4) begin
                            if (u2 == 16'h000A) dec.adv = 3'd4;
                        end else if (!r_fin) begin
                            dec.hold = 1'b1;
                        end
                    end
                    dec.kind = f_kind(dec.cp, (dec.cp < 21'h80) ? KIND_ASCII : KIND_WIDE);
                end
            end
            ENC_UTF8: begin
                if (!r_buf[0][7]) begin
                    dec = f_single(r_buf[0], r_buf[1], r_cnt, r_fin);
                end else begin
                    if (r_buf[0][7:5] == 3'b110)       extra = 2'd1;
                    else if (r_buf[0][7:4] == 4'b1110) extra = 2'd2;
                    else if (r_buf[0][7:3] == 5'b11110) extra = 2'd3;
                    else                                lead_ok = 1'b0;
                    if (!lead_ok) begin
                        dec = f_skip();
                    end else if (r_cnt < {1'b0, extra} + 3'd1) begin
                        dec      = f_skip();
                        dec.hold = !r_fin;
                    end else begin
                        bad = (r_buf[1][7:6] != 2'b10)
                            || (extra >= 2'd2 && r_buf[2][7:6] != 2'b10)
                            || (extra == 2'd3 && r_buf[3][7:6] != 2'b10);
                        case (extra)
                            2'd1:    cpu = {10'd0, r_buf[0][4:0], r_buf[1][5:0]};
                            2'd2:    cpu = {5'd0, r_buf[0][3:0], r_buf[1][5:0],
                                            r_buf[2][5:0]};
                            default: cpu = {r_buf[0][2:0], r_buf[1][5:0],
                                            r_buf[2][5:0], r_buf[3][5:0]};
                        endcase
                        if (bad || cpu > 21'h10FFFF) begin
                            dec = f_skip();
                        end else begin
                            dec.cp   = cpu;
                            dec.kind = (cpu < 21'h80) ? KIND_ASCII : KIND_WIDE;
                            dec.adv  = {1'b0, extra} + 3'd1;
                        end
                    end
                end
            end
            ENC_GBK: begin
                dec = f_single(r_buf[0], r_buf[1], r_cnt, r_fin);
                if (r_buf[0] >= 8'h81) begin
                    if (r_cnt >= 3'd2) begin
                        if (r_buf[1] >= 8'h40 && r_buf[1] != 8'h7F) begin
                            dec      = '0;
                            dec.hi   = r_buf[0];
                            dec.lo   = r_buf[1];
                            dec.kind = KIND_WIDE;
                            dec.adv  = 3'd2;
                        end
                    end else if (!r_fin) begin
                        dec.hold = 1'b1;
                    end
                end
            end
            default: dec = f_skip();
        endcase
    end

    assign o_sts.can_emit = (r_cnt != 3'd0) && !dec.hold;

    // buffer after consuming dec.adv bytes; entries past the count are zero
    always_comb begin
        for (int i = 0; i < 2*DEPTH; i++) begin
            ext[i] = (i < DEPTH) ? r_buf[i % DEPTH] : 8'h00;
        end
        for (int i = 0; i < DEPTH; i++) begin
            n_buf[i] = 8'h00;
            if (dec.adv != 3'd0 && dec.adv < r_cnt) begin
                for (int k = 1; k < DEPTH; k++) begin
                    if (dec.adv == 3'(k)) n_buf[i] = ext[i + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_fin <= 1'b0;
            for (int i = 0; i < DEPTH; i++) r_buf[i] <= 8'h00;
        end else if (i_cmd.append) begin
            r_fin <= i_in_item.end_of_text;
            if (r_cnt < 3'(DEPTH)) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (r_cnt == 3'(i)) r_buf[i] <= i_in_item.data_byte;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end else if (i_cmd.load) begin
            r_buf <= n_buf;
            r_cnt <= (dec.adv == 3'd0 || dec.adv >= r_cnt) ? 3'd0 : r_cnt - dec.adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_stg <= dec;
        if (i_cmd.move) begin
            r_out.code_point  <= r_stg.cp;
            r_out.char_kind   <= r_stg.kind;
            r_out.gbk_high    <= r_stg.hi;
            r_out.gbk_low     <= r_stg.lo;
            r_out.byte_count  <= r_stg.adv;
            r_out.last_of_run <= i_cmd.move_last;
        end
    end

    assign o_out_item = r_out;

endmodule

### sv/mecd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the character decoder, bound to the top level.
// Depends on mecd_pkg and multi_encoding_text_char_decoder_core.
module mecd_checker
    import mecd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // an output item held back must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output item changed while stalled");

    // a byte just taken keeps the input side busy while it is decoded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted twice in a row");

    // the tail mark consumes nothing and always closes the run
    a_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.char_kind == KIND_TAIL
        |-> o_out_item.byte_count == 3'd0 && o_out_item.last_of_run)
        else $error("tail item malformed");

    // a GBK pair takes exactly two bytes and reports no code point
    a_gbk_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.gbk_high != 8'h00
        |-> o_out_item.byte_count == 3'd2 && o_out_item.code_point == 21'd0
            && o_out_item.char_kind == KIND_WIDE)
        else $error("gbk pair malformed");

endmodule

bind multi_encoding_text_char_decoder_core mecd_checker u_mecd_checker (.*);

### tb/mecd_char_checker.sv
`timescale 1ns / 1ps
// Checker for the multi-encoding character decoder: watches both item channels
// and the APB port, predicts decoded characters and compares them in order.
// Depends on mecd_pkg only.
module mecd_char_checker
    import mecd_pkg::*;
#(
    parameter logic [CFG_AW-1:0] ENC_REG_ADDR = '0
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_item          i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         i_out_item,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    input  logic [CFG_DW-1:0] i_prdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_chars_owed
);

    t_enc       enc_reg = ENC_UTF8;
    logic [7:0] pend_buf [DEPTH];
    int         pend_cnt = 0;
    t_out_item  char_expect_q [$];
    int         fail_cnt = 0;
    int         owed_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_chars_owed = owed_cnt;

    task automatic report_miss(input string msg);
        fail_cnt++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    function automatic t_kind ctl_kind(input logic [20:0] cp, input t_kind plain);
        if (cp == 21'h0A || cp == 21'h0D) return KIND_NEWLINE;
        if (cp == 21'h09) return KIND_TAB;
        if (cp < 21'h20) return KIND_SKIP;
        return plain;
    endfunction

    function automatic logic [15:0] unit16(input t_enc enc, input int at);
        if (enc == ENC_UTF16LE) return {pend_buf[at + 1], pend_buf[at]};
        return {pend_buf[at], pend_buf[at + 1]};
    endfunction

    // one byte character; a CR needs to see the next byte for a possible LF
    function automatic int decode_single(input logic fin, output t_out_item ch);
        ch = '0;
        ch.code_point = {13'd0, pend_buf[0]};
        ch.char_kind  = ctl_kind(ch.code_point, KIND_ASCII);
        if (pend_buf[0] == 8'h0D) begin
            if (pend_cnt >= 2) return (pend_buf[1] == 8'h0A) ? 2 : 1;
            if (!fin) return -1;
        end
        return 1;
    endfunction

    // -1: wait for more bytes, else bytes consumed (0 for an odd UTF-16 tail)
    function automatic int decode_head(input t_enc enc, input logic fin,
                                       output t_out_item ch);
        logic [20:0] cp;
        logic [15:0] u;
        logic [15:0] u2;
        logic [7:0]  b0;
        int          extra;
        int          adv;
        int          i;
        ch = '0;
        case (enc)
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (pend_cnt < 2) begin
                    if (!fin) return -1;
                    ch.char_kind = KIND_TAIL;
                    return 0;
                end
                u   = unit16(enc, 0);
                cp  = {5'd0, u};
                adv = 2;
                if (u >= 16'hD800 && u <= 16'hDBFF) begin
                    if (pend_cnt >= 4) begin
                        u2 = unit16(enc, 2);
                        if (u2 >= 16'hDC00 && u2 <= 16'hDFFF) begin
                            cp  = 21'h10000 + {1'b0, u[9:0], u2[9:0]};
                            adv = 4;
                        end
                    end else if (!fin) begin
                        return -1;
                    end
                end
                if (cp == 21'h0D) begin
                    if (pend_cnt >= 4) begin
                        if (unit16(enc, 2) == 16'h000A) adv = 4;
                    end else if (!fin) begin
                        return -1;
                    end
                end
                ch.code_point = cp;
                ch.char_kind  = ctl_kind(cp, (cp < 21'h80) ? KIND_ASCII : KIND_WIDE);
                return adv;
            end
            ENC_UTF8: begin
                b0 = pend_buf[0];
                if (!b0[7]) return decode_single(fin, ch);
                if (b0[7:5] == 3'b110) begin
                    extra = 1;
                    cp    = {16'd0, b0[4:0]};
                end else if (b0[7:4] == 4'b1110) begin
                    extra = 2;
                    cp    = {17'd0, b0[3:0]};
                end else if (b0[7:3] == 5'b11110) begin
                    extra = 3;
                    cp    = {18'd0, b0[2:0]};
                end else begin
                    ch.char_kind = KIND_SKIP;
                    return 1;
                end
                if (pend_cnt < extra + 1) begin
                    if (!fin) return -1;
                    ch.char_kind = KIND_SKIP;
                    return 1;
                end
                for (i = 1; i <= extra; i++) begin
                    if (pend_buf[i][7:6] != 2'b10) begin
                        ch.char_kind = KIND_SKIP;
                        return 1;
                    end
                    cp = {cp[14:0], pend_buf[i][5:0]};
                end
                if (cp > 21'h10FFFF) begin
                    ch.char_kind = KIND_SKIP;
                    return 1;
                end
                ch.code_point = cp;
                ch.char_kind  = (cp < 21'h80) ? KIND_ASCII : KIND_WIDE;
                return extra + 1;
            end
            default: begin
                if (pend_buf[0] >= 8'h81) begin
                    if (pend_cnt >= 2) begin
                        if (pend_buf[1] >= 8'h40 && pend_buf[1] != 8'h7F) begin
                            ch.gbk_high  = pend_buf[0];
                            ch.gbk_low   = pend_buf[1];
                            ch.char_kind = KIND_WIDE;
                            return 2;
                        end
                    end else if (!fin) begin
                        return -1;
                    end
                end
                return decode_single(fin, ch);
            end
        endcase
    endfunction

    task automatic absorb_byte(input t_in_item item);
        t_out_item ch;
        t_out_item held;
        bit        have_held;
        int        adv;
        int        n;
        int        i;
        if (pend_cnt < DEPTH) begin
            pend_buf[pend_cnt] = item.data_byte;
            pend_cnt++;
        end
        n = 0;
        have_held = 1'b0;
        while (pend_cnt > 0 && n < MAX_RES) begin
            adv = decode_head(enc_reg, item.end_of_text, ch);
            if (adv < 0) break;
            ch.byte_count = 3'(adv);
            if (have_held) char_expect_q.push_back(held);
            held = ch;
            have_held = 1'b1;
            n++;
            if (adv == 0 || adv >= pend_cnt) begin
                for (i = 0; i < DEPTH; i++) pend_buf[i] = 8'h00;
                pend_cnt = 0;
            end else begin
                for (i = 0; i < DEPTH; i++)
                    pend_buf[i] = (i + adv < pend_cnt) ? pend_buf[i + adv] : 8'h00;
                pend_cnt -= adv;
            end
        end
        // only the final character of the item carries the run flag
        if (have_held) begin
            held.last_of_run = 1'b1;
            char_expect_q.push_back(held);
        end
    endtask

    task automatic check_field(input string name, input logic [20:0] got,
                               input logic [20:0] want);
        if (got !== want) report_miss($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_char(input t_out_item got);
        t_out_item want;
        if (char_expect_q.size() == 0) begin
            report_miss($sformatf("char %h with none expected", got));
            return;
        end
        want = char_expect_q.pop_front();
        check_field("code_point", got.code_point, want.code_point);
        check_field("char_kind", got.char_kind, want.char_kind);
        check_field("gbk_high", got.gbk_high, want.gbk_high);
        check_field("gbk_low", got.gbk_low, want.gbk_low);
        check_field("byte_count", got.byte_count, want.byte_count);
        check_field("last_of_run", got.last_of_run, want.last_of_run);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            enc_reg  = ENC_UTF8;
            pend_cnt = 0;
            for (int i = 0; i < DEPTH; i++) pend_buf[i] = 8'h00;
            char_expect_q.delete();
        end else begin
            // a result leaving now cannot stem from a byte taken at this edge
            if (i_out_valid && !i_out_stall) check_char(i_out_item);
            if (i_in_valid && !i_in_stall) absorb_byte(i_in_item);
            if (i_psel && i_penable && i_pready && i_paddr == ENC_REG_ADDR) begin
                if (i_pwrite)
                    enc_reg = i_pwdata[1:0];
                else if (i_prdata[1:0] !== enc_reg)
                    report_miss($sformatf("encoding read %0h want %0h",
                                          i_prdata[1:0], enc_reg));
            end
        end
        owed_cnt = char_expect_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the multi-encoding character decoder core.
// Depends on mecd_pkg, the core and mecd_char_checker.
module tb_top;
    import mecd_pkg::*;

    localparam int                CYCLE_LIMIT = 400000;
    localparam int                LONG_HOLD   = 300;
    localparam int                SETTLE      = 12;
    localparam int                RAND_BYTES  = 410;
    localparam int                PHASE_BYTES = 46;
    localparam logic [CFG_AW-1:0] REG_TEXT_ENC = '0;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_stall;
    t_out_item         out_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    int         fails;
    int         owed;
    int         cycle_cnt = 0;
    bit         calm = 1'b0;
    bit         hold_req = 1'b0;
    logic [7:0] text_q [$];

    always #5 clk = ~clk;

    multi_encoding_text_char_decoder_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    mecd_char_checker #(.ENC_REG_ADDR(REG_TEXT_ENC)) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_fail_count(fails),
        .o_chars_owed(owed)
    );

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output back-pressure: short bursts, the odd long one, one very long hold
    initial begin : out_stall_gen
        int burst;
        int r;
        bit served;
        out_stall = 1'b0;
        burst = 0;
        served = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !served) begin
                served = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                burst = 0;
            end else if (burst > 0) begin
                burst--;
            end else if (calm) begin
                out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    out_stall <= 1'b1;
                    burst = (r < 32) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end else begin
                    out_stall <= 1'b0;
                    burst = $urandom_range(0, 5);
                end
            end
        end
    end

    // all tasks below start and finish at a falling edge
    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (calm || r < 60) n = 0;
        else if (r < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(6, 30);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        t_in_item it;
        it.data_byte   = b;
        it.end_of_text = eot;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        idle_gap();
    endtask

    task automatic send_text(input bit with_eot);
        foreach (text_q[i]) send_byte(text_q[i], with_eot && (i == text_q.size() - 1));
        text_q.delete();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (owed != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic cfg_access(input bit wr, input t_enc enc);
        logic [CFG_DW-1:0] w;
        w = $urandom;
        w[1:0] = enc;
        psel    <= 1'b1;
        pwrite  <= wr;
        penable <= 1'b0;
        paddr   <= REG_TEXT_ENC;
        pwdata  <= w;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // lowest n bytes of v, most significant first
    task automatic put_bytes(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) text_q.push_back(v[8 * i +: 8]);
    endtask

    task automatic put16(input t_enc enc, input logic [15:0] u);
        if (enc == ENC_UTF16LE) put_bytes({u[7:0], u[15:8]}, 2);
        else put_bytes(u, 2);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // mostly well-formed characters, some broken sequences and raw noise
    task automatic add_char(input t_enc enc);
        int         r;
        bit         r2;
        logic [7:0] lo;
        r  = $urandom_range(0, 99);
        r2 = 1'($urandom_range(0, 1));
        case (enc)
            ENC_UTF8: begin
                if (r < 28) put_bytes(8'($urandom_range(8'h20, 8'h7F)), 1);
                else if (r < 36) put_bytes(8'($urandom_range(0, 8'h1F)), 1);
                else if (r < 42) put_bytes(16'h0D0A, 2);
                else if (r < 54) put_bytes({8'($urandom_range(8'hC0, 8'hDF)), cont_byte()}, 2);
                else if (r < 66)
                    put_bytes({8'($urandom_range(8'hE0, 8'hEF)), cont_byte(), cont_byte()}, 3);
                else if (r < 76)
                    put_bytes({8'($urandom_range(8'hF0, 8'hF7)), cont_byte(), cont_byte(),
                               cont_byte()}, 4);
                else if (r < 84)
                    put_bytes(r2 ? 8'($urandom_range(8'h80, 8'hBF))
                                 : 8'($urandom_range(8'hF8, 8'hFF)), 1);
                else if (r < 92)
                    // lead cut short by a plain letter
                    put_bytes({8'($urandom_range(8'hE0, 8'hF4)), cont_byte(),
                               8'($urandom_range(8'h41, 8'h5A))}, 3);
                else put_bytes(8'($urandom), 1);
            end
            ENC_UTF16LE, ENC_UTF16BE: begin
                if (r < 20) put16(enc, 16'($urandom_range(16'h20, 16'h7E)));
                else if (r < 40) put16(enc, 16'($urandom));
                else if (r < 48) begin
                    put16(enc, 16'h000D);
                    put16(enc, 16'h000A);
                end else if (r < 54) begin
                    put16(enc, 16'h000D);
                    put16(enc, 16'($urandom_range(16'h20, 16'h7E)));
                end else if (r < 72) begin
                    put16(enc, 16'($urandom_range(16'hD800, 16'hDBFF)));
                    put16(enc, 16'($urandom_range(16'hDC00, 16'hDFFF)));
                end else if (r < 78) begin
                    put16(enc, 16'($urandom_range(16'hD800, 16'hDBFF)));
                    put16(enc, 16'($urandom_range(16'h20, 16'h7E)));
                end else if (r < 84) put16(enc, 16'($urandom_range(16'hDC00, 16'hDFFF)));
                else if (r < 92) put16(enc, 16'($urandom_range(0, 16'h1F)));
                else put_bytes(8'($urandom), 1);
            end
            default: begin
                if (r < 30) put_bytes(8'($urandom_range(8'h20, 8'h7F)), 1);
                else if (r < 38) put_bytes(8'($urandom_range(0, 8'h1F)), 1);
                else if (r < 44) put_bytes(16'h0D0A, 2);
                else if (r < 74) begin
                    lo = 8'($urandom_range(8'h40, 8'hFF));
                    if (lo == 8'h7F) lo = 8'h80;
                    put_bytes({8'($urandom_range(8'h81, 8'hFF)), lo}, 2);
                end else if (r < 82) begin
                    lo = r2 ? 8'h7F : 8'($urandom_range(0, 8'h3F));
                    put_bytes({8'($urandom_range(8'h81, 8'hFF)), lo}, 2);
                end else if (r < 88) put_bytes(8'h80, 1);
                else put_bytes(8'($urandom), 1);
            end
        endcase
    endtask

    initial begin : stimulus
        int   ph;
        int   nchars;
        int   phase_bytes;
        int   rand_bytes;
        t_enc enc;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset encoding is UTF-8
        cfg_access(1'b0, ENC_UTF8);
        // control, tab, CR LF, bad lead, top scalar, bad continuation,
        // truncated lead at end of text
        put_bytes(40'h00_09_0D_0A_FF, 5);
        put_bytes(48'hF4_8F_BF_BF_C3_28, 6);
        put_bytes(16'hE2_82, 2);
        send_text(1'b1);
        wait_drained();
        // surrogate pair, lone high surrogate, odd trailing byte
        cfg_access(1'b1, ENC_UTF16BE);
        put_bytes(64'hD8_3D_DE_00_DB_FF_00_41, 8);
        put_bytes(8'h41, 1);
        send_text(1'b1);
        wait_drained();
        // pair, then a lone 0x80 byte, which is not a GBK lead byte
        cfg_access(1'b1, ENC_GBK);
        put_bytes(24'h81_40_80, 3);
        send_text(1'b1);

        ph = 0;
        rand_bytes = 0;
        while (rand_bytes < RAND_BYTES) begin
            wait_drained();
            case (ph)
                0: enc = ENC_UTF16LE;
                1: enc = ENC_GBK;
                2: enc = ENC_UTF8;
                3: enc = ENC_UTF16BE;
                default: enc = t_enc'($urandom_range(0, 3));
            endcase
            cfg_access(1'b1, enc);
            cfg_access(1'b0, enc);
            calm = (ph % 4 == 3);
            if (ph == 2) hold_req = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20)
                                                      : $urandom_range(1, 6);
                repeat (nchars) add_char(enc);
                phase_bytes += text_q.size();
                // a text left open carries its bytes into the next encoding
                send_text($urandom_range(0, 99) < 80);
            end
            rand_bytes += phase_bytes;
            ph++;
        end

        wait_drained();
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
